FILE: src/aes_iks_pkg.sv
// Shared types, constants and functions for the AES-128 inverse key schedule.
// S-box table, round constants and one backward key-expansion round.
// No dependencies.
package aes_iks_pkg;

    localparam int WORD_W              = 32;
    localparam int KEY_W               = 4 * WORD_W;
    localparam int MAX_ROUNDS          = 10;
    localparam int ROUNDS_BACK_DEFAULT = 10;
    localparam int ROUND_W             = 4;

    typedef logic [WORD_W-1:0]  t_word;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [ROUND_W-1:0] t_round;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] rcon(input t_round round);
        logic [7:0] rc;
        case (round)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

    // RotWord then SubWord; byte 0 is bits 31:24
    function automatic t_word sub_rot(input t_word x);
        t_word r;
        r = {x[23:0], x[31:24]};
        return {SBOX[r[31:24]], SBOX[r[23:16]], SBOX[r[15:8]], SBOX[r[7:0]]};
    endfunction

    // key packing: word i in bits 32i+31:32i
    function automatic t_key back_round(input t_key key, input t_round round);
        t_word k0, k1, k2, k3;
        t_word p0, p1, p2, p3;
        k0 = key[0*WORD_W +: WORD_W];
        k1 = key[1*WORD_W +: WORD_W];
        k2 = key[2*WORD_W +: WORD_W];
        k3 = key[3*WORD_W +: WORD_W];
        p3 = k3 ^ k2;
        p2 = k2 ^ k1;
        p1 = k1 ^ k0;
        p0 = k0 ^ {rcon(round), 24'h000000} ^ sub_rot(p3);
        return {p3, p2, p1, p0};
    endfunction

endpackage

FILE: src/aes_iks_round.sv
// One pipeline stage of the inverse key schedule: a single backward round.
// Depends on aes_iks_pkg.
module aes_iks_round #(
    parameter int ROUND = aes_iks_pkg::MAX_ROUNDS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  aes_iks_pkg::t_key        i_key,
    output logic                     o_valid,
    output aes_iks_pkg::t_key        o_key
);

    logic              r_valid;
    aes_iks_pkg::t_key r_key;
    aes_iks_pkg::t_key n_key;

    assign n_key = aes_iks_pkg::back_round(i_key, aes_iks_pkg::ROUND_W'(ROUND));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_key <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_key   = r_key;

endmodule

FILE: src/aes128_inverse_key_schedule.sv
// Top level of the AES-128 inverse key schedule pipeline.
// Depends on aes_iks_pkg and aes_iks_round.
//
// Usage:
//   Slave channel takes a last round key word (four 32-bit words in tdata),
//   master channel returns the recovered cipher key in the same layout.
//   Word i sits in tdata bits 32i+31:32i, its byte 4i in the top byte.
//   The pipeline has ROUNDS_BACK stages (capped at 10), one backward
//   key-expansion round each (XOR chain, four S-box lookups, XOR). Throughput
//   is one word per cycle while the receiver does not stall the output.
//   All stages advance together; the last stage is the output register.
//   When the receiver stalls with a word waiting, the whole pipeline holds
//   and o_s_tready drops; empty slots in front of the output keep moving
//   only when the output is free. Nothing is dropped or duplicated.
//   Synchronous active-low reset clears all stage valid bits; data
//   registers are not reset. With ROUNDS_BACK below 10 the last rounds
//   (10 down to 11 - ROUNDS_BACK) are run and the matching round key out.
module aes128_inverse_key_schedule #(
    parameter int ROUNDS_BACK = aes_iks_pkg::ROUNDS_BACK_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // round_key_word0, round_key_word1, round_key_word2, round_key_word3
    input  logic [aes_iks_pkg::KEY_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // cipher_key_word0, cipher_key_word1, cipher_key_word2, cipher_key_word3
    output logic [aes_iks_pkg::KEY_W-1:0]   o_m_tdata
);

    localparam int STAGES = (ROUNDS_BACK > aes_iks_pkg::MAX_ROUNDS) ? aes_iks_pkg::MAX_ROUNDS :
                            ((ROUNDS_BACK < 0) ? 0 : ROUNDS_BACK);

    logic                    w_en;
    logic [STAGES:0]         w_valid;
    aes_iks_pkg::t_key       w_key [STAGES+1];

    assign w_en       = !w_valid[STAGES] || i_m_tready;
    assign o_s_tready = w_en;
    assign w_valid[0] = i_s_tvalid;
    assign w_key[0]   = i_s_tdata;

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        aes_iks_round #(
            .ROUND(aes_iks_pkg::MAX_ROUNDS - s)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[s]),
            .i_key   (w_key[s]),
            .o_valid (w_valid[s+1]),
            .o_key   (w_key[s+1])
        );
    end

    assign o_m_tvalid = w_valid[STAGES];
    assign o_m_tdata  = w_key[STAGES];

endmodule

FILE: src/aes_iks_checker.sv
// Port-level checks for aes128_inverse_key_schedule, bound to the top level.
// Depends on aes_iks_pkg.
module aes_iks_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [aes_iks_pkg::KEY_W-1:0]   o_m_tdata
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled output word changed");

    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("input ready does not follow output backpressure");

    a_out_from_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(o_s_tready))
        else $error("output word appeared while pipeline was stalled");

endmodule

bind aes128_inverse_key_schedule aes_iks_checker u_aes_iks_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
